/* hw/rtl/text_console_cursor_controller_assert.svh */
// ----------------------------------------------------------------------------
// Text console cursor controller assertion macros
// Shared property forms for the port checker of the cursor controller.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_CONTROLLER_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_CONTROLLER_ASSERT_SVH

// same-cycle implication, clocked on clock, off while reset is high
`define TCC_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off while reset is high
`define TCC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/tcc_pkg.sv */
// ----------------------------------------------------------------------------
// Text console cursor controller package
// Widths, character codes, state and result types, and cursor helpers.
// ----------------------------------------------------------------------------
package tcc_pkg;

   localparam int MAX_ROWS    = 128;
   localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COORD_W     = 11;
   localparam int WORK_W      = COORD_W + 1;
   localparam int CODE_W      = 8;
   localparam int CSR_IDX_W   = 1;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_PAD_W   = RSP_TDATA_W - CODE_W - 2 * COORD_W;
   localparam int CELL_SHIFT  = 4;

   localparam int RUN_MAX     = 3;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 1'd1;

   localparam logic [COORD_W-1:0] WIDTH_RESET  = 11'd1920;
   localparam logic [COORD_W-1:0] HEIGHT_RESET = 11'd1080;
   localparam logic [COORD_W-1:0] COORD_MAX    = '1;

   localparam logic [CODE_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CODE_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CODE_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'h7F;
   localparam logic [CODE_W-1:0] CH_BLANK     = 8'h20;

   localparam logic [WORK_W-1:0] CELL     = 12'd16;
   localparam logic [WORK_W-1:0] TAB_STEP = 12'd64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAW,
      ST_WRAP,
      ST_FLUSH
   } state_type;

   typedef enum logic {
      OP_DRAW   = 1'b0,
      OP_SCROLL = 1'b1
   } op_type;

   typedef struct packed {
      op_type              op_kind;
      logic [CODE_W-1:0]   glyph_code;
      logic [COORD_W-1:0]  pos_x;
      logic [COORD_W-1:0]  pos_y;
      logic                last_of_run;
   } result_type;

   function automatic logic [WORK_W-1:0] sub_floor(input logic [WORK_W-1:0] a);
      return (a >= CELL) ? (a - CELL) : '0;
   endfunction

   function automatic logic [COORD_W-1:0] cap11(input logic [WORK_W-1:0] v);
      return (v > {1'b0, COORD_MAX}) ? COORD_MAX : v[COORD_W-1:0];
   endfunction

   function automatic logic [ROW_W-1:0] row_of(input logic [WORK_W-1:0] y);
      logic [31:0] r;
      r = 32'(y >> CELL_SHIFT);
      if (r >= 32'(MAX_ROWS)) begin
         return ROW_W'(MAX_ROWS - 1);
      end
      return ROW_W'(r);
   endfunction

   function automatic logic [ROW_W-1:0] row_slot(input logic [ROW_W-1:0] base,
                                                 input logic [ROW_W-1:0] row);
      logic [ROW_W:0] sum;
      sum = {1'b0, base} + {1'b0, row};
      if (sum >= (ROW_W + 1)'(MAX_ROWS)) begin
         sum = sum - (ROW_W + 1)'(MAX_ROWS);
      end
      return sum[ROW_W-1:0];
   endfunction

endpackage

/* hw/rtl/text_console_cursor_controller.sv */
// ----------------------------------------------------------------------------
// Text console cursor controller
// Turns character codes into glyph draw and scroll commands for a console.
// ----------------------------------------------------------------------------
// Usage: one character per req_ transaction (req_tdata[7:0]). Each character
// yields zero to three commands on rsp_: draw a 16x16 cell (rsp_tuser 0) or
// scroll up one text row and clear the bottom row (rsp_tuser 1); rsp_tlast
// marks the final command of a character. screen_width and screen_height must
// be written on csr_ only while the block is idle; the block does not enforce this.
// Sequencing: the cursor sequencer runs a pre-move, a draw and a wrap step per
// character, plus a flush step when the wrap check ends in a scroll; the
// pre-move and wrap steps share the single row-end table write port. A
// one-entry input buffer holds the character in work, and the next character
// is accepted in the cycle that the current one finishes.
// Row ends sit in a 128-entry memory addressed through a rotating base, so a
// scroll moves the base and clears one valid bit instead of copying rows.
// Reset: cursor at (0, 0), all row ends zero, sizes 1920 x 1080, queues empty.
// Stall: commands wait in a 4-entry output queue; a new character starts only
// when the queue has room for three commands, so req_tready drops when the
// receiver holds rsp_tready low.
// ----------------------------------------------------------------------------
module text_console_cursor_controller
   import tcc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_TDATA_W-1:0]  req_tdata,   // [7:0] char_code
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,   // [7:0] glyph_code, [18:8] pos_x,
                                                // [29:19] pos_y, [31:30] zero
   output logic                    rsp_tuser,   // [0] op_kind
   output logic                    rsp_tlast,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [COORD_W-1:0]      csr_wdata
);

   logic [COORD_W-1:0]    width_ff, height_ff;
   logic [COORD_W-1:0]    cur_x_ff, cur_y_ff, cur_x_in, cur_y_in;
   logic [WORK_W-1:0]     work_x_ff, work_y_ff, work_x_in, work_y_in;
   logic                  lookup_ff, lookup_in;
   state_type             state_ff, state_in;

   logic                  in_valid_ff;
   logic [CODE_W-1:0]     in_char_ff;
   logic                  accept, consume;

   logic [COORD_W-1:0]    table_mem [MAX_ROWS];
   logic [MAX_ROWS-1:0]   valid_ff, valid_in;
   logic [ROW_W-1:0]      base_ff;
   logic [COORD_W-1:0]    rd_data_ff;
   logic                  rd_valid_ff;
   logic [ROW_W-1:0]      rd_addr, tbl_waddr;
   logic [COORD_W-1:0]    tbl_wdata;
   logic                  tbl_we, scroll_en;

   result_type            pend_ff, pend_in;
   logic                  pend_valid_ff, pend_valid_in;
   result_type            push_data;
   logic                  push, pop;

   result_type            fifo_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic                  fifo_room;
   result_type            head;

   assign consume    = ((state_ff == ST_WRAP) && (state_in == ST_IDLE)) ||
                       (state_ff == ST_FLUSH);
   assign req_tready = !in_valid_ff || consume;
   assign accept     = req_tvalid && req_tready;
   assign fifo_room  = count_ff <= FIFO_CNT_W'(FIFO_DEPTH - RUN_MAX);

   always_comb begin
      logic [WORK_W-1:0] w12, h12, cx, cy, x, y, bs_x, rec_x, rec_y;
      logic              rec_en, new_valid, run_end;
      result_type        new_res;

      w12 = {1'b0, width_ff};
      h12 = {1'b0, height_ff};
      cx  = {1'b0, cur_x_ff};
      cy  = {1'b0, cur_y_ff};
      x = '0;
      y = '0;
      bs_x = '0;
      rec_x = '0;
      rec_y = '0;
      rec_en = 1'b0;
      new_valid = 1'b0;
      new_res = '0;
      run_end = 1'b0;
      scroll_en = 1'b0;
      state_in = state_ff;
      work_x_in = work_x_ff;
      work_y_in = work_y_ff;
      lookup_in = lookup_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      rd_addr = row_slot(base_ff, row_of(sub_floor(cy)));

      case (state_ff)
         ST_IDLE: begin
            if (in_valid_ff && fifo_room) begin
               state_in = ST_DRAW;
               lookup_in = 1'b0;
               work_x_in = cx;
               work_y_in = cy;
               case (in_char_ff)
                  CH_NEWLINE: begin
                     rec_en = 1'b1;
                     rec_x = cx;
                     rec_y = cy;
                     work_x_in = '0;
                     work_y_in = cy + CELL;
                  end
                  CH_RETURN: begin
                     work_x_in = '0;
                  end
                  CH_TAB: begin
                     if (cx + CELL >= w12) begin
                        rec_en = 1'b1;
                        rec_x = cx;
                        rec_y = cy;
                        work_x_in = '0;
                        work_y_in = (cy + CELL <= h12) ? (cy + CELL) : sub_floor(h12);
                     end
                  end
                  CH_BACKSPACE: begin
                     if ((cx == '0) && (cy != '0)) begin
                        lookup_in = 1'b1;
                        work_y_in = sub_floor(cy);
                     end else begin
                        work_x_in = sub_floor(cx);
                     end
                  end
                  default: begin
                     if (cy + CELL >= h12) begin
                        scroll_en = 1'b1;
                        work_x_in = '0;
                        work_y_in = sub_floor(cy);
                        new_valid = 1'b1;
                        new_res.op_kind = OP_SCROLL;
                        new_res.pos_y = cap11(sub_floor(cy));
                     end
                  end
               endcase
            end
         end
         ST_DRAW: begin
            state_in = ST_WRAP;
            case (in_char_ff)
               CH_NEWLINE, CH_RETURN: begin
               end
               CH_TAB: begin
                  if (work_y_ff < h12) begin
                     new_valid = 1'b1;
                     new_res.op_kind = OP_DRAW;
                     new_res.glyph_code = CH_BLANK;
                     new_res.pos_x = cap11(work_x_ff);
                     new_res.pos_y = cap11(work_y_ff);
                  end
                  work_x_in = work_x_ff + TAB_STEP;
               end
               CH_BACKSPACE: begin
                  if (lookup_ff) begin
                     bs_x = rd_valid_ff ? {1'b0, rd_data_ff} : '0;
                  end else begin
                     bs_x = work_x_ff;
                  end
                  new_valid = 1'b1;
                  new_res.op_kind = OP_DRAW;
                  new_res.glyph_code = CH_BLANK;
                  new_res.pos_x = cap11(bs_x);
                  new_res.pos_y = cap11(work_y_ff);
                  work_x_in = bs_x;
               end
               default: begin
                  new_valid = 1'b1;
                  new_res.op_kind = OP_DRAW;
                  new_res.glyph_code = in_char_ff;
                  new_res.pos_x = cap11(work_x_ff);
                  new_res.pos_y = cap11(work_y_ff);
                  work_x_in = work_x_ff + CELL;
               end
            endcase
         end
         ST_WRAP: begin
            x = work_x_ff;
            y = work_y_ff;
            if (x >= w12) begin
               rec_en = 1'b1;
               rec_x = x;
               rec_y = y;
               x = '0;
               y = y + CELL;
            end
            if (y >= h12) begin
               scroll_en = 1'b1;
               x = '0;
               y = sub_floor(y);
               new_valid = 1'b1;
               new_res.op_kind = OP_SCROLL;
               new_res.pos_y = cap11(y);
               state_in = ST_FLUSH;
            end else begin
               run_end = 1'b1;
               state_in = ST_IDLE;
            end
            cur_x_in = cap11(x);
            cur_y_in = cap11(y);
         end
         ST_FLUSH: begin
            run_end = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      tbl_we    = rec_en;
      tbl_waddr = row_slot(base_ff, row_of(rec_y));
      tbl_wdata = cap11(sub_floor(rec_x));

      push = 1'b0;
      push_data = pend_ff;
      pend_in = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (new_valid) begin
         if (pend_valid_ff) begin
            push = 1'b1;
            push_data.last_of_run = 1'b0;
         end
         pend_in = new_res;
         pend_valid_in = 1'b1;
      end else if (run_end && pend_valid_ff) begin
         push = 1'b1;
         push_data.last_of_run = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   // mark written rows, drop the row that leaves on a scroll
   always_comb begin
      valid_in = valid_ff;
      if (tbl_we) begin
         valid_in[tbl_waddr] = 1'b1;
      end
      if (scroll_en) begin
         valid_in[base_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         in_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         base_ff <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         pend_valid_ff <= pend_valid_in;
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (consume) begin
            in_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  width_ff <= csr_wdata;
               CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         valid_ff <= valid_in;
         if (scroll_en) begin
            base_ff <= (base_ff == ROW_W'(MAX_ROWS - 1)) ? '0 : base_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_x_ff <= work_x_in;
      work_y_ff <= work_y_in;
      lookup_ff <= lookup_in;
      pend_ff <= pend_in;
      if (accept) begin
         in_char_ff <= req_tdata[CODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_mem[tbl_waddr] <= tbl_wdata;
      end
      rd_data_ff <= table_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = count_ff != '0;
   assign head       = fifo_mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, head.pos_y, head.pos_x, head.glyph_code};
   assign rsp_tuser = head.op_kind;
   assign rsp_tlast = head.last_of_run;

endmodule

/* hw/rtl/tcc_checker.sv */
// ----------------------------------------------------------------------------
// Text console cursor controller port checker
// Watches the controller ports for command and reset behavior.
// ----------------------------------------------------------------------------
`include "text_console_cursor_controller_assert.svh"

module tcc_checker
   import tcc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RSP_TDATA_W-1:0]  rsp_tdata,   // [7:0] glyph_code, [18:8] pos_x,
                                               // [29:19] pos_y, [31:30] zero
   input logic                    rsp_tuser,   // [0] op_kind
   input logic                    rsp_tlast
);

   // hold a stalled command
   `TCC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled command changed")

   // scroll commands carry no glyph and start at column zero
   `TCC_ASSERT_NOW(a_scroll_fields, rsp_tvalid && (rsp_tuser == OP_SCROLL),
      rsp_tdata[CODE_W+COORD_W-1:0] == '0, "scroll command with glyph or column")

   // come out of reset empty and ready
   `TCC_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_tvalid && req_tready,
      "not empty after reset")

endmodule

bind text_console_cursor_controller tcc_checker u_tcc_checker (.*);

/* sim/console_command_check.sv */
// ----------------------------------------------------------------------------
// Console command checker
// Watches the character, command and size ports of the cursor controller,
// predicts the draw and scroll commands of every accepted character from its
// own cursor, row-end table and screen size, and compares each command that
// leaves the block, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module console_command_check
   import tcc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                    rsp_tuser,
   input  logic                    rsp_tlast,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [COORD_W-1:0]      csr_wdata,
   output int                      mismatches,
   output int                      pending,
   output int                      draws_checked,
   output int                      scrolls_checked
);

   logic [COORD_W-1:0] scr_w;
   logic [COORD_W-1:0] scr_h;
   logic [COORD_W-1:0] cur_x;
   logic [COORD_W-1:0] cur_y;
   logic [COORD_W-1:0] line_end [MAX_ROWS];

   int                 wx;
   int                 wy;
   result_type         cmd_run[$];
   result_type         cmd_expect[$];

   initial begin
      mismatches      = 0;
      pending         = 0;
      draws_checked   = 0;
      scrolls_checked = 0;
   end

   function automatic int clamp11(input int v);
      return (v > 2047) ? 2047 : v;
   endfunction

   function automatic int floor_cell(input int v);
      return (v >= 16) ? v - 16 : 0;
   endfunction

   function automatic logic [ROW_W-1:0] row_index(input int y);
      return (y / 16 >= MAX_ROWS) ? ROW_W'(MAX_ROWS - 1) : ROW_W'(y / 16);
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t ns] command mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("command %0d %s got 0x%0h want 0x%0h",
                                   draws_checked + scrolls_checked, name, got, want));
      end
   endtask

   task automatic issue(input op_type kind, input logic [CODE_W-1:0] glyph,
                        input int px, input int py);
      result_type r;
      r.op_kind     = kind;
      r.glyph_code  = glyph;
      r.pos_x       = px[COORD_W-1:0];
      r.pos_y       = py[COORD_W-1:0];
      r.last_of_run = 1'b0;
      cmd_run.push_back(r);
   endtask

   task automatic record_line_end();
      line_end[row_index(wy)] = COORD_W'(clamp11(floor_cell(wx)));
   endtask

   task automatic scroll_screen();
      wx = 0;
      wy = floor_cell(wy);
      for (int i = 0; i < MAX_ROWS - 1; i++) begin
         line_end[ROW_W'(i)] = line_end[ROW_W'(i + 1)];
      end
      line_end[MAX_ROWS - 1] = '0;
      issue(OP_SCROLL, '0, 0, clamp11(wy));
   endtask

   task automatic apply_char(input logic [CODE_W-1:0] ch);
      int w;
      int h;
      w  = int'(scr_w);
      h  = int'(scr_h);
      wx = int'(cur_x);
      wy = int'(cur_y);
      cmd_run.delete();
      case (ch)
         CH_NEWLINE: begin
            record_line_end();
            wx = 0;
            wy += 16;
         end
         CH_RETURN: begin
            wx = 0;
         end
         CH_TAB: begin
            if (wx + 16 >= w) begin
               record_line_end();
               wx = 0;
               if (wy + 16 <= h) begin
                  wy += 16;
               end else begin
                  wy = floor_cell(h);
               end
            end
            if (wy < h) begin
               issue(OP_DRAW, CH_BLANK, clamp11(wx), clamp11(wy));
            end
            wx += 64;
         end
         CH_BACKSPACE: begin
            if (wx == 0 && wy > 0) begin
               wy = floor_cell(wy);
               wx = int'(line_end[row_index(wy)]);
            end else begin
               wx = floor_cell(wx);
            end
            issue(OP_DRAW, CH_BLANK, clamp11(wx), clamp11(wy));
         end
         default: begin
            if (wy + 16 >= h) begin
               scroll_screen();
            end
            issue(OP_DRAW, ch, clamp11(wx), clamp11(wy));
            wx += 16;
         end
      endcase
      if (wx >= w) begin
         record_line_end();
         wx = 0;
         wy += 16;
      end
      if (wy >= h) begin
         scroll_screen();
      end
      cur_x = COORD_W'(clamp11(wx));
      cur_y = COORD_W'(clamp11(wy));
      if (cmd_run.size() > 0) begin
         cmd_run[cmd_run.size() - 1].last_of_run = 1'b1;
      end
      foreach (cmd_run[i]) begin
         cmd_expect.push_back(cmd_run[i]);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         scr_w = WIDTH_RESET;
         scr_h = HEIGHT_RESET;
         cur_x = '0;
         cur_y = '0;
         foreach (line_end[i]) begin
            line_end[i] = '0;
         end
         cmd_expect.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (cmd_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected command tdata 0x%08h tuser %0d",
                                         rsp_tdata, rsp_tuser));
            end else begin
               want = cmd_expect.pop_front();
               check_field("op_kind", int'(rsp_tuser), int'(want.op_kind));
               check_field("glyph_code", int'(rsp_tdata[7:0]), int'(want.glyph_code));
               check_field("pos_x", int'(rsp_tdata[18:8]), int'(want.pos_x));
               check_field("pos_y", int'(rsp_tdata[29:19]), int'(want.pos_y));
               check_field("padding", int'(rsp_tdata[31:30]), 0);
               check_field("last_of_run", int'(rsp_tlast), int'(want.last_of_run));
               if (want.op_kind == OP_SCROLL) begin
                  scrolls_checked++;
               end else begin
                  draws_checked++;
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_SCREEN_WIDTH) begin
               scr_w = csr_wdata;
            end else if (csr_index == CSR_SCREEN_HEIGHT) begin
               scr_h = csr_wdata;
            end
         end
         if (req_tvalid && req_tready) begin
            apply_char(req_tdata[CODE_W-1:0]);
         end
      end
      pending = cmd_expect.size();
   end

endmodule

/* sim/tb_text_console_cursor_controller.sv */
// ----------------------------------------------------------------------------
// Text console cursor controller testbench
// Feeds directed and random character streams through several screen sizes,
// including zero and both extremes, with random gaps on the character side
// and random stalls on the command side; the command checker predicts and
// compares every command and the top reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_text_console_cursor_controller;
   import tcc_pkg::*;

   localparam int PHASES     = 7;
   localparam int PHASE_LEN  = 55;
   localparam int SETTLE     = 12;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b1;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index  = CSR_SCREEN_WIDTH;
   logic [COORD_W-1:0]      csr_wdata  = '0;

   int                      mismatches;
   int                      pending;
   int                      draws_checked;
   int                      scrolls_checked;
   int                      chars_sent = 0;
   int                      sizes_used = 1;
   bit                      calm       = 1'b0;

   always #4 clock = ~clock;

   text_console_cursor_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   console_command_check command_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .pending         (pending),
      .draws_checked   (draws_checked),
      .scrolls_checked (scrolls_checked)
   );

   task automatic send_char(input logic [CODE_W-1:0] ch);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tdata  <= ch;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      chars_sent++;
   endtask

   // hold off the sender until every predicted command has come back
   task automatic drain_commands();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_screen_size(input logic [COORD_W-1:0] w,
                                    input logic [COORD_W-1:0] h);
      csr_we    <= 1'b1;
      csr_index <= CSR_SCREEN_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= CSR_SCREEN_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [CODE_W-1:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 9)  return CH_NEWLINE;
      if (r < 13) return CH_RETURN;
      if (r < 21) return CH_TAB;
      if (r < 31) return CH_BACKSPACE;
      if (r < 38) return CODE_W'($urandom_range(0, 255));
      if (r < 45) return CH_BLANK;
      return CODE_W'($urandom_range(8'h21, 8'h7E));
   endfunction

   always begin
      @(negedge clock);
      if (!reset) begin
         if (calm || $urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge clock);
         end
      end
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      logic [CODE_W-1:0]  opening [9];
      logic [CODE_W-1:0]  narrow [14];
      logic [COORD_W-1:0] widths [PHASES];
      logic [COORD_W-1:0] heights [PHASES];
      int                 waited;
      int                 leftover;

      opening = '{8'h41, 8'h00, 8'hFF, CH_TAB, CH_NEWLINE, CH_BACKSPACE,
                  CH_RETURN, CH_BACKSPACE, CH_BACKSPACE};
      narrow  = '{8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, CH_TAB,
                  CH_NEWLINE, CH_NEWLINE, CH_BACKSPACE, CH_BACKSPACE, 8'h80, 8'h7E};
      widths  = '{11'd64, 11'd16, 11'd2047, 11'd0,
                  COORD_W'($urandom_range(16, 400)), COORD_W'($urandom_range(16, 400)),
                  WIDTH_RESET};
      heights = '{11'd48, 11'd16, 11'd2047, 11'd0,
                  COORD_W'($urandom_range(16, 300)), COORD_W'($urandom_range(16, 300)),
                  HEIGHT_RESET};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (opening[i]) begin
         send_char(opening[i]);
      end
      drain_commands();
      write_screen_size(11'd64, 11'd48);
      sizes_used++;
      foreach (narrow[i]) begin
         send_char(narrow[i]);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain_commands();
         write_screen_size(widths[p], heights[p]);
         sizes_used++;
         calm = (p == PHASES - 1);
         for (int i = 0; i < PHASE_LEN; i++) begin
            if (p == 0 && i == PHASE_LEN / 2) begin
               drain_commands();
            end
            send_char(pick_char());
         end
      end

      req_tvalid <= 1'b0;
      waited = 0;
      while (pending != 0 && waited < 2000) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE) @(negedge clock);
      leftover = pending;
      if (leftover != 0) begin
         $display("%0d predicted commands never left the block", leftover);
      end

      $display("covered %0d characters over %0d screen size settings",
               chars_sent, sizes_used);
      $display("checked %0d draw and %0d scroll commands", draws_checked, scrolls_checked);
      if (mismatches == 0 && leftover == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/tcc_pkg.sv
hw/rtl/text_console_cursor_controller.sv
hw/rtl/tcc_checker.sv
sim/console_command_check.sv
sim/tb_text_console_cursor_controller.sv
